[hdl/npte_pkg.sv]
// Package for the phonetic spelling encoder: word table, case modes and register map.
// Used by nato_phonetic_text_encoder; depends on nothing else.

package npte_pkg;

  localparam int NUM_WORDS  = 36;
  localparam int DIGIT_BASE = 26;
  localparam int SLOT_W     = $clog2(NUM_WORDS);
  localparam int TXT_W      = 64;
  localparam int LEN_W      = 4;
  localparam int APB_AW     = 4;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [1:0]        case_mode_t;

  localparam case_mode_t CASE_LOWER  = 2'd0;
  localparam case_mode_t CASE_UPPER  = 2'd1;
  localparam case_mode_t CASE_FIRST  = 2'd2;
  localparam case_mode_t CASE_FOLLOW = 2'd3;

  localparam logic FOLLOW_FIRST = 1'b0;
  localparam logic FOLLOW_UPPER = 1'b1;

  typedef enum logic [1:0] {
    REG_LETTER_CASE = 2'd0,
    REG_FOLLOW_CASE = 2'd1,
    REG_DIGIT_CASE  = 2'd2
  } reg_idx_t;

  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  // Words are right-justified: the last letter sits in the low byte.
  localparam logic [TXT_W-1:0] WORD_TXT [NUM_WORDS] = '{
    64'("alpha"),   64'("bravo"),   64'("charlie"), 64'("delta"),
    64'("echo"),    64'("foxtrot"), 64'("golf"),    64'("hotel"),
    64'("india"),   64'("juliett"), 64'("kilo"),    64'("lima"),
    64'("mike"),    64'("november"), 64'("oscar"),  64'("papa"),
    64'("quebec"),  64'("romeo"),   64'("sierra"),  64'("tango"),
    64'("uniform"), 64'("victor"),  64'("whiskey"), 64'("x-ray"),
    64'("yankee"),  64'("zulu"),    64'("zero"),    64'("one"),
    64'("two"),     64'("tree"),    64'("fower"),   64'("fife"),
    64'("six"),     64'("seven"),   64'("eight"),   64'("niner")
  };

  localparam len_t WORD_LEN [NUM_WORDS] = '{
    4'd5, 4'd5, 4'd7, 4'd5, 4'd4, 4'd7, 4'd4, 4'd5,
    4'd5, 4'd7, 4'd4, 4'd4, 4'd4, 4'd8, 4'd5, 4'd4,
    4'd6, 4'd5, 4'd6, 4'd5, 4'd7, 4'd6, 4'd7, 4'd5,
    4'd6, 4'd4, 4'd4, 4'd3, 4'd3, 4'd4, 4'd5, 4'd4,
    4'd3, 4'd5, 4'd5, 4'd5
  };

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

endpackage

[hdl/nato_phonetic_text_encoder.sv]
// Phonetic spelling encoder: one item in, one result byte per cycle out.
// Each item is held in the item register; result bytes leave through the output register.
// A letter or digit gives its word and a period (4 to 9 bytes), any other byte is passed
// unchanged; busy drops while the last byte is formed, so the next item follows gap-free.
// Reset (rst_n low, synchronous) clears the case registers and any item in progress.
// Depends on npte_pkg; the receiver cannot stall.

module nato_phonetic_text_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [7:0]                  in_char,
  output logic                        out_valid,
  output logic [7:0]                  out_char,
  output logic                        out_last_of_run,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [npte_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import npte_pkg::*;

  case_mode_t letter_mode_r;
  logic       follow_mode_r;
  case_mode_t digit_mode_r;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  logic       act_r,  act_nxt;
  logic       pass_r;
  logic [7:0] char_r;
  slot_t      slot_r;
  logic       all_caps_r;
  logic       first_cap_r;
  len_t       idx_r,  idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r,  out_char_nxt;
  logic       out_last_r,  out_last_nxt;

  logic       is_upper, is_lower, is_digit;
  slot_t      in_slot;
  case_mode_t in_mode;
  logic       in_all_caps, in_first_cap;
  logic       accept;

  len_t             cur_len;
  logic [2:0]       pos;
  logic [TXT_W-1:0] shifted;
  logic [7:0]       word_ch;
  logic             is_last;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_mode_r <= CASE_LOWER;
      follow_mode_r <= FOLLOW_FIRST;
      digit_mode_r  <= CASE_LOWER;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LETTER_CASE: letter_mode_r <= pwdata[1:0];
        REG_FOLLOW_CASE: follow_mode_r <= pwdata[0];
        REG_DIGIT_CASE:  digit_mode_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_LETTER_CASE: prdata[1:0] = letter_mode_r;
      REG_FOLLOW_CASE: prdata[0]   = follow_mode_r;
      REG_DIGIT_CASE:  prdata[1:0] = digit_mode_r;
      default:         prdata      = '0;
    endcase
  end

  // Decode of the incoming byte.
  always_comb begin
    is_upper = (in_char >= CH_UP_A) && (in_char <= CH_UP_Z);
    is_lower = (in_char >= CH_LO_A) && (in_char <= CH_LO_Z);
    is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
    if (is_upper) begin
      in_slot = SLOT_W'(in_char - CH_UP_A);
    end else if (is_lower) begin
      in_slot = SLOT_W'(in_char - CH_LO_A);
    end else begin
      in_slot = SLOT_W'(in_char - CH_ZERO) + SLOT_W'(DIGIT_BASE);
    end
    // Digits in follow mode borrow the letter mode.
    if (is_digit) begin
      in_mode = (digit_mode_r == CASE_FOLLOW) ? letter_mode_r : digit_mode_r;
    end else begin
      in_mode = letter_mode_r;
    end
    in_all_caps  = (in_mode == CASE_UPPER) ||
                   (in_mode == CASE_FOLLOW && follow_mode_r == FOLLOW_UPPER && is_upper);
    in_first_cap = !in_all_caps &&
                   ((in_mode == CASE_FIRST) ||
                    (in_mode == CASE_FOLLOW && follow_mode_r == FOLLOW_FIRST && is_upper));
  end

  // Byte generation for the item held in the item register.
  always_comb begin
    cur_len = WORD_LEN[slot_r];
    pos     = 3'(cur_len - idx_r - len_t'(1));
    shifted = WORD_TXT[slot_r] >> {pos, 3'b000};
    word_ch = shifted[7:0];
    if (all_caps_r || (first_cap_r && idx_r == '0)) begin
      word_ch = upcase(word_ch);
    end
    is_last = pass_r || (idx_r == cur_len);
  end

  assign busy   = act_r && !is_last;
  assign accept = start && !busy;

  always_comb begin
    act_nxt       = act_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (act_r) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = is_last;
      if (pass_r) begin
        out_char_nxt = char_r;
      end else if (idx_r == cur_len) begin
        out_char_nxt = CH_PERIOD;
      end else begin
        out_char_nxt = word_ch;
      end
      idx_nxt = idx_r + len_t'(1);
      if (is_last) begin
        act_nxt = 1'b0;
      end
    end
    if (accept) begin
      act_nxt = 1'b1;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (accept) begin
      pass_r      <= !(is_upper || is_lower || is_digit);
      char_r      <= in_char;
      slot_r      <= in_slot;
      all_caps_r  <= in_all_caps;
      first_cap_r <= in_first_cap;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;

endmodule
